// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MARGIN_W        = 12;
    localparam int POS_W           = 18;
    localparam int POS_FRAC        = 16;
    localparam int QUO_W           = POS_FRAC + 1;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1);
    localparam logic [POS_FRAC:0]   POS_ONE      = {1'b1, {POS_FRAC{1'b0}}};

    localparam logic signed [1:0] OU_ABOVE = 2'sb01;
    localparam logic signed [1:0] OU_BELOW = 2'sb11;
    localparam logic signed [1:0] OU_NONE  = 2'sb00;

    typedef struct packed {
        logic negdet;
        logic nz;
        logic in0;
        logic in1;
        logic crossed;
        logic above;
    } t_flags;

endpackage

// ===== hw/rtl/psc_pair_if.sv =====
interface psc_pair_if #(
    parameter int W = psc_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_start_x;
    logic signed [W-1:0] a_start_y;
    logic signed [W-1:0] a_start_z;
    logic signed [W-1:0] a_end_x;
    logic signed [W-1:0] a_end_y;
    logic signed [W-1:0] a_end_z;
    logic signed [W-1:0] b_start_x;
    logic signed [W-1:0] b_start_y;
    logic signed [W-1:0] b_start_z;
    logic signed [W-1:0] b_end_x;
    logic signed [W-1:0] b_end_y;
    logic signed [W-1:0] b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
               b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );
endinterface

// ===== hw/rtl/psc_res_if.sv =====
interface psc_res_if;
    logic                              valid;
    logic                              ready;
    logic                              crossed;
    logic signed [psc_pkg::POS_W-1:0]  signed_position;
    logic signed [1:0]                 over_under;

    modport source (output valid, crossed, signed_position, over_under, input ready);
    modport sink   (input valid, crossed, signed_position, over_under, output ready);
endinterface

// ===== hw/rtl/projected_segment_crossing_top.sv =====
// channel  dir  handshake     beat
// i_pair   in   valid/ready   two 3D segments, 12 signed coordinates
// o_res    out  valid/ready   crossed, signed_position, over_under
// cfg      in   i_cfg_we      edge_margin, 12 bits
//
// One beat accepted per cycle while o_res does not stall; the 4-stage det/numerator
// front feeds 17 division stages for the Q0.16 parameter, the last one rounding.
// Reset (i_rst_n low, synchronous) clears the valid bits and sets edge_margin to 1.
// A stall at o_res freezes every stage together; i_pair.ready falls only while
// the output register holds an untaken beat.
module projected_segment_crossing_top
    import psc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [MARGIN_W-1:0] i_cfg_wdata,
    psc_pair_if.sink            i_pair,
    psc_res_if.source           o_res
);
    localparam int W   = COORD_WIDTH;
    localparam int D   = 2 * W + 3;          // det / numerator width
    localparam int L   = W + 2;              // low split of det and n for the z products
    localparam int Z   = D + W + 3;          // height comparison width
    localparam int C   = D + POS_FRAC + 2;   // margin comparison width
    localparam int NST = 22;
    localparam int DV0 = 3;                  // stage holding the division seed
    localparam int DVL = DV0 + QUO_W;        // last division stage (rounding)

    logic [MARGIN_W-1:0] r_margin;
    logic [NST-1:0]      r_vld;
    logic                en;

    assign en           = !r_vld[NST-1] || o_res.ready;
    assign i_pair.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_margin <= i_cfg_wdata;
            end
            if (en) begin
                r_vld <= {r_vld[NST-2:0], i_pair.valid};
            end
        end
    end

    // stage 0: differences
    logic signed [W:0]   r_dx1, r_dy1, r_e, r_f, r_gx, r_gy, r_dza0, r_dzb0;
    logic signed [W-1:0] r_az0_0, r_bz0_0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1   <= (W+1)'(i_pair.a_end_x)   - (W+1)'(i_pair.a_start_x);
            r_dy1   <= (W+1)'(i_pair.a_end_y)   - (W+1)'(i_pair.a_start_y);
            r_e     <= (W+1)'(i_pair.b_start_x) - (W+1)'(i_pair.b_end_x);
            r_f     <= (W+1)'(i_pair.b_start_y) - (W+1)'(i_pair.b_end_y);
            r_gx    <= (W+1)'(i_pair.b_start_x) - (W+1)'(i_pair.a_start_x);
            r_gy    <= (W+1)'(i_pair.b_start_y) - (W+1)'(i_pair.a_start_y);
            r_dza0  <= (W+1)'(i_pair.a_end_z)   - (W+1)'(i_pair.a_start_z);
            r_dzb0  <= (W+1)'(i_pair.b_end_z)   - (W+1)'(i_pair.b_start_z);
            r_az0_0 <= i_pair.a_start_z;
            r_bz0_0 <= i_pair.b_start_z;
        end
    end

    // stage 1: six products
    logic signed [2*W+1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    logic signed [W:0]     r_dza1, r_dzb1;
    logic signed [W-1:0]   r_az0_1, r_bz0_1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1    <= r_dx1 * r_f;
            r_p2    <= r_e * r_dy1;
            r_p3    <= r_f * r_gx;
            r_p4    <= r_e * r_gy;
            r_p5    <= r_dx1 * r_gy;
            r_p6    <= r_dy1 * r_gx;
            r_dza1  <= r_dza0;
            r_dzb1  <= r_dzb0;
            r_az0_1 <= r_az0_0;
            r_bz0_1 <= r_bz0_0;
        end
    end

    // stage 2: det and numerators
    logic signed [D-1:0] r_det, r_n0, r_n1;
    logic signed [W:0]   r_dza2, r_dzb2;
    logic signed [W-1:0] r_az0_2, r_bz0_2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det   <= D'(r_p1) - D'(r_p2);
            r_n0    <= D'(r_p3) - D'(r_p4);
            r_n1    <= D'(r_p5) - D'(r_p6);
            r_dza2  <= r_dza1;
            r_dzb2  <= r_dzb1;
            r_az0_2 <= r_az0_1;
            r_bz0_2 <= r_bz0_1;
        end
    end

    // stage 3: normalise to det >= 0; seeds the division chain
    logic [D-1:0]        r_dr [DV0:DVL];
    logic [D-1:0]        r_dd [DV0:DVL];
    logic [QUO_W-1:0]    r_dq [DV0:DVL];
    t_flags              r_flg[DV0:DVL];
    logic signed [D-1:0] r_n1p;
    logic signed [W:0]   r_dza3, r_dzb3;
    logic signed [W-1:0] r_az0_3, r_bz0_3;
    logic                negdet;

    assign negdet = r_det[D-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[DV0]  <= negdet ? -r_det : r_det;
            r_dr[DV0]  <= negdet ? -r_n0  : r_n0;
            r_dq[DV0]  <= '0;
            r_n1p      <= negdet ? -r_n1  : r_n1;
            r_flg[DV0] <= '{negdet: negdet, nz: (r_det != '0), in0: 1'b0, in1: 1'b0,
                            crossed: 1'b0, above: 1'b0};
            r_dza3     <= r_dza2;
            r_dzb3     <= r_dzb2;
            r_az0_3    <= r_az0_2;
            r_bz0_3    <= r_bz0_2;
        end
    end

    // stage 4: margin bounds and split height products
    logic [D+MARGIN_W-1:0]     r_lo;
    logic [D+POS_FRAC:0]       r_hi;
    logic signed [D-1:0]       r_n0_4, r_n1_4;
    logic signed [W+L:0]       r_pa_l, r_qa_l;
    logic signed [W+D-L:0]     r_pa_h, r_qa_h;
    logic signed [W+L+1:0]     r_pb_l, r_qb_l;
    logic signed [W+D-L:0]     r_pb_h, r_qb_h;
    logic signed [D-1:0]       n0s;
    logic [POS_FRAC:0]         one_m;

    assign n0s   = $signed(r_dr[DV0]);
    assign one_m = POS_ONE - (POS_FRAC+1)'(r_margin);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lo   <= r_margin * r_dd[DV0];
            r_hi   <= one_m * r_dd[DV0];
            r_n0_4 <= n0s;
            r_n1_4 <= r_n1p;
            r_pa_l <= r_az0_3 * $signed({1'b0, r_dd[DV0][L-1:0]});
            r_pa_h <= r_az0_3 * $signed({1'b0, r_dd[DV0][D-1:L]});
            r_pb_l <= r_dza3 * $signed({1'b0, n0s[L-1:0]});
            r_pb_h <= r_dza3 * $signed(n0s[D-1:L]);
            r_qa_l <= r_bz0_3 * $signed({1'b0, r_dd[DV0][L-1:0]});
            r_qa_h <= r_bz0_3 * $signed({1'b0, r_dd[DV0][D-1:L]});
            r_qb_l <= r_dzb3 * $signed({1'b0, r_n1p[L-1:0]});
            r_qb_h <= r_dzb3 * $signed(r_n1p[D-1:L]);
        end
    end

    // stage 5: margin compares, partial height sums
    logic signed [C-1:0] s0, s1, loc, hic;
    logic                in0, in1;
    logic signed [Z-1:0] r_a1, r_a2, r_b1, r_b2;

    assign s0  = C'($signed({r_n0_4, {POS_FRAC{1'b0}}}));
    assign s1  = C'($signed({r_n1_4, {POS_FRAC{1'b0}}}));
    assign loc = $signed(C'(r_lo));
    assign hic = $signed(C'(r_hi));
    assign in0 = (s0 > loc) && (hic > s0);
    assign in1 = (s1 > loc) && (hic > s1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1 <= (Z'(r_pa_h) <<< L) + Z'(r_pa_l);
            r_a2 <= (Z'(r_pb_h) <<< L) + Z'(r_pb_l);
            r_b1 <= (Z'(r_qa_h) <<< L) + Z'(r_qa_l);
            r_b2 <= (Z'(r_qb_h) <<< L) + Z'(r_qb_l);
        end
    end

    // stage 6: heights at the crossing
    logic signed [Z-1:0] r_lhs, r_rhs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lhs <= r_a1 + r_a2;
            r_rhs <= r_b1 + r_b2;
        end
    end

    // division chain, one quotient bit a stage, last stage rounds
    t_flags           n_flg[DV0+1:DVL];
    logic [D-1:0]     n_dr [DV0+1:DVL];
    logic [QUO_W-1:0] n_dq [DV0+1:DVL];

    for (genvar j = DV0 + 1; j <= DVL; j++) begin : g_div
        logic [D:0] r2;
        logic       ge;
        assign r2 = {r_dr[j-1], 1'b0};
        assign ge = r2 >= {1'b0, r_dd[j-1]};

        always_comb begin
            n_flg[j] = r_flg[j-1];
            if (j == 5) begin
                n_flg[j].in0 = in0;
                n_flg[j].in1 = in1;
            end
            if (j == 6) begin
                n_flg[j].crossed = r_flg[j-1].nz && r_flg[j-1].in0 && r_flg[j-1].in1;
            end
            if (j == 7) begin
                n_flg[j].above = r_lhs > r_rhs;
            end
            if (j == DVL) begin
                n_dr[j] = r_dr[j-1];
                n_dq[j] = r_dq[j-1] + QUO_W'(ge);
            end else begin
                n_dr[j] = ge ? D'(r2 - {1'b0, r_dd[j-1]}) : D'(r2);
                n_dq[j] = {r_dq[j-1][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dd[j]  <= r_dd[j-1];
                r_dr[j]  <= n_dr[j];
                r_dq[j]  <= n_dq[j];
                r_flg[j] <= n_flg[j];
            end
        end
    end

    // output register
    logic                     r_crossed;
    logic signed [POS_W-1:0]  r_pos;
    logic signed [1:0]        r_ou;
    logic signed [POS_W-1:0]  qs;
    t_flags                   fl;

    assign fl = r_flg[DVL];
    assign qs = $signed(POS_W'(r_dq[DVL]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crossed <= fl.crossed;
            r_pos     <= !fl.crossed ? '0 : ((fl.above != fl.negdet) ? -qs : qs);
            r_ou      <= !fl.crossed ? OU_NONE : (fl.above ? OU_ABOVE : OU_BELOW);
        end
    end

    assign o_res.valid           = r_vld[NST-1];
    assign o_res.crossed         = r_crossed;
    assign o_res.signed_position = r_pos;
    assign o_res.over_under      = r_ou;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.crossed |-> o_res.signed_position == '0 && o_res.over_under == OU_NONE)
        else $error("no crossing but non-zero result");

    a_cross_ou: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.crossed |-> o_res.over_under == OU_ABOVE || o_res.over_under == OU_BELOW)
        else $error("crossing without over/under");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && $stable(r_pos))
        else $error("pipeline moved during stall");

endmodule
